FILE: hw/rtl/mbfc_pkg.sv
// ----------------------------------------------------------------------------
// Motion box framing controller package
// Shared constants, configuration register indexes, command codes and the sequencer states.
// ----------------------------------------------------------------------------
package mbfc_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int WINDOW_LEN_DEF = 8;
	localparam int COORD_BITS_DEF = 12;

	// Fixed widths of the configuration registers
	localparam int DIM_BITS  = 12;
	localparam int HOLD_BITS = 8;
	localparam int CFG_IDX_BITS = 2;

	// Reset values of the configuration registers
	localparam logic [DIM_BITS-1:0]  FRAME_WIDTH_RST  = 12'd320;
	localparam logic [DIM_BITS-1:0]  FRAME_HEIGHT_RST = 12'd240;
	localparam logic [HOLD_BITS-1:0] HOLD_TICKS_RST   = 8'd3;

	// Tick counter saturates here
	localparam logic [HOLD_BITS-1:0] TICK_MAX = 8'd255;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TICKS   = 2'd2;

	// Input command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_FRAME  = 1'b1;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} mbfc_state_t;

endpackage

FILE: hw/rtl/motion_box_framing_controller.sv
// ----------------------------------------------------------------------------
// Motion box framing controller
// Keeps windows of recent motion-box edges in a row of cells, reduces them to
// the window extremes and issues pan, tilt, zoom and capture requests.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | command, motion_found, box_*
//  out     | out_valid/out_ready  | pan_*, tilt_*, zoom_*, issue_move,
//          |                      | capture_picture
//
//  Ticks and quiet frames give a registered result in the cycle after acceptance.
//  A motion frame shifts the window; the running min/max then crosses the chain
//  cell by cell, and the decision is registered once the output register is free.
//  One transaction is worked on at a time; input is taken again once the output
//  register is empty or its result leaves it in the same cycle.
//  No clearing pass after reset: entries reset to their values, running extremes are not reset.
//  cfg_ready is always high; output stalls hold the block in place.
// ----------------------------------------------------------------------------
module motion_box_framing_controller #(
	parameter int WINDOW_LEN = mbfc_pkg::WINDOW_LEN_DEF,
	parameter int COORD_BITS = mbfc_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbfc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mbfc_pkg::DIM_BITS-1:0]     cfg_data,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic                              motion_found,
	input  logic [COORD_BITS-1:0]             box_left,
	input  logic [COORD_BITS-1:0]             box_right,
	input  logic [COORD_BITS-1:0]             box_bottom,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              pan_left,
	output logic                              pan_right,
	output logic                              tilt_up,
	output logic                              tilt_down,
	output logic                              zoom_closer,
	output logic                              zoom_wider,
	output logic                              issue_move,
	output logic                              capture_picture
);

	localparam int CNT_BITS = $clog2(WINDOW_LEN + 1);
	localparam logic [CNT_BITS-1:0] SCAN_LEN = CNT_BITS'(WINDOW_LEN);
	localparam int EW = ((COORD_BITS > mbfc_pkg::DIM_BITS) ?
		COORD_BITS : mbfc_pkg::DIM_BITS) + 2;
	localparam logic [COORD_BITS-1:0] LEFT_RST =
		COORD_BITS'(mbfc_pkg::FRAME_WIDTH_RST);

	// Configuration registers
	logic [mbfc_pkg::DIM_BITS-1:0]  frame_width_q, frame_height_q;
	logic [mbfc_pkg::HOLD_BITS-1:0] hold_ticks_q;

	// Control state
	mbfc_pkg::mbfc_state_t state_q, state_d;
	logic [CNT_BITS-1:0]            cnt_q;
	logic [mbfc_pkg::HOLD_BITS-1:0] ticks_q;
	logic                           picture_taken_q;
	logic                           out_valid_q;

	// Result register
	logic pan_left_q, pan_right_q, tilt_up_q, tilt_down_q;
	logic zoom_closer_q, zoom_wider_q, issue_move_q, capture_q;

	// Handshake and control terms
	logic in_fire, out_free, scan_done, load_quick, load_scan, out_load;
	logic motion_fire, hold_passed, do_capture;

	// Cell chain wiring
	logic [COORD_BITS-1:0] left_c   [WINDOW_LEN];
	logic [COORD_BITS-1:0] right_c  [WINDOW_LEN];
	logic [COORD_BITS-1:0] bottom_c [WINDOW_LEN];
	logic [COORD_BITS-1:0] minl_c   [WINDOW_LEN];
	logic [COORD_BITS-1:0] maxr_c   [WINDOW_LEN];
	logic [COORD_BITS-1:0] maxb_c   [WINDOW_LEN];

	// Decision terms
	logic [EW-1:0] ml, mr, mb, w, wh, wq, w3, hh, hq, h3;
	logic d_pan_left, d_pan_right, d_tilt_up, d_tilt_down;
	logic d_zoom_closer, d_zoom_wider;

	assign cfg_ready   = 1'b1;
	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == mbfc_pkg::ST_IDLE) && out_free;
	assign in_fire     = in_valid && in_ready;
	assign motion_fire = in_fire && (command == mbfc_pkg::CMD_FRAME) && motion_found;
	assign load_quick  = in_fire && !motion_fire;
	assign scan_done   = (state_q == mbfc_pkg::ST_SCAN) && (cnt_q == SCAN_LEN);
	assign load_scan   = scan_done && out_free;
	assign out_load    = load_quick || load_scan;
	assign hold_passed = ticks_q > hold_ticks_q;
	assign do_capture  = (command == mbfc_pkg::CMD_FRAME) && !picture_taken_q && hold_passed;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= mbfc_pkg::FRAME_WIDTH_RST;
			frame_height_q <= mbfc_pkg::FRAME_HEIGHT_RST;
			hold_ticks_q   <= mbfc_pkg::HOLD_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbfc_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				mbfc_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				mbfc_pkg::CFG_HOLD_TICKS:
					hold_ticks_q <= cfg_data[mbfc_pkg::HOLD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Row of window cells; cell 0 seeds the reduction with its own entry
	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
			logic [COORD_BITS-1:0] l_in, r_in, b_in, ml_in, mr_in, mb_in;
			if (gi == 0) begin : g_head
				assign l_in  = box_left;
				assign r_in  = box_right;
				assign b_in  = box_bottom;
				assign ml_in = left_c[0];
				assign mr_in = right_c[0];
				assign mb_in = bottom_c[0];
			end else begin : g_body
				assign l_in  = left_c[gi-1];
				assign r_in  = right_c[gi-1];
				assign b_in  = bottom_c[gi-1];
				assign ml_in = minl_c[gi-1];
				assign mr_in = maxr_c[gi-1];
				assign mb_in = maxb_c[gi-1];
			end
			mbfc_cell #(
				.COORD_BITS (COORD_BITS),
				.LEFT_RESET (LEFT_RST)
			) u_cell (
				.clk            (clk),
				.arst_n         (arst_n),
				.shift_en       (motion_fire),
				.left_in        (l_in),
				.right_in       (r_in),
				.bottom_in      (b_in),
				.min_left_in    (ml_in),
				.max_right_in   (mr_in),
				.max_bottom_in  (mb_in),
				.left_out       (left_c[gi]),
				.right_out      (right_c[gi]),
				.bottom_out     (bottom_c[gi]),
				.min_left_out   (minl_c[gi]),
				.max_right_out  (maxr_c[gi]),
				.max_bottom_out (maxb_c[gi])
			);
		end
	endgenerate

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbfc_pkg::ST_IDLE: if (motion_fire) state_d = mbfc_pkg::ST_SCAN;
			mbfc_pkg::ST_SCAN: if (load_scan) state_d = mbfc_pkg::ST_IDLE;
			default: state_d = mbfc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Scan counter: cycles since the window last shifted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (motion_fire) begin
			cnt_q <= '0;
		end else if (cnt_q != SCAN_LEN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Extremes from the chain tail against frame quarters and halves
	always_comb begin
		ml = EW'(minl_c[WINDOW_LEN-1]);
		mr = EW'(maxr_c[WINDOW_LEN-1]);
		mb = EW'(maxb_c[WINDOW_LEN-1]);
		w  = EW'(frame_width_q);
		wh = EW'(frame_width_q >> 1);
		wq = EW'(frame_width_q >> 2);
		w3 = wh + wq;
		hh = EW'(frame_height_q >> 1);
		hq = EW'(frame_height_q >> 2);
		h3 = hh + hq;
		d_pan_left  = 1'b0;
		d_pan_right = 1'b0;
		// width - right < left, rearranged to stay unsigned
		if (w < ml + mr) begin
			if (ml < wq) d_pan_left = 1'b1;
			else if (ml > wh) d_pan_right = 1'b1;
		end else begin
			if (mr > w3) d_pan_left = 1'b1;
			else if (mr < wq) d_pan_right = 1'b1;
		end
		d_tilt_down = mb > h3;
		d_tilt_up   = !d_tilt_down && (mb < hh);
		// span = right - left, compared as right against left + threshold
		d_zoom_closer = mr < ml + wh;
		d_zoom_wider  = !d_zoom_closer && (mr > ml + w3);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load_quick) begin
			{pan_left_q, pan_right_q, tilt_up_q, tilt_down_q} <= '0;
			{zoom_closer_q, zoom_wider_q, issue_move_q}       <= '0;
			capture_q <= do_capture;
		end else if (load_scan) begin
			pan_left_q    <= hold_passed && d_pan_left;
			pan_right_q   <= hold_passed && d_pan_right;
			tilt_up_q     <= hold_passed && d_tilt_up;
			tilt_down_q   <= hold_passed && d_tilt_down;
			zoom_closer_q <= hold_passed && d_zoom_closer;
			zoom_wider_q  <= hold_passed && d_zoom_wider;
			issue_move_q  <= hold_passed;
			capture_q     <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold counter and picture flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q         <= '0;
			picture_taken_q <= 1'b0;
		end else begin
			if (in_fire && (command == mbfc_pkg::CMD_TICK)) begin
				if (ticks_q != mbfc_pkg::TICK_MAX) ticks_q <= ticks_q + 1'b1;
			end else if (load_scan && hold_passed) begin
				ticks_q <= '0;
			end
			if (motion_fire) begin
				picture_taken_q <= 1'b0;
			end else if (load_quick && do_capture) begin
				picture_taken_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign pan_left        = pan_left_q;
	assign pan_right       = pan_right_q;
	assign tilt_up         = tilt_up_q;
	assign tilt_down       = tilt_down_q;
	assign zoom_closer     = zoom_closer_q;
	assign zoom_wider      = zoom_wider_q;
	assign issue_move      = issue_move_q;
	assign capture_picture = capture_q;

	// Checks
	a_bits_need_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !issue_move |->
			!(pan_left || pan_right || tilt_up || tilt_down || zoom_closer || zoom_wider))
		else $error("movement bits set without a move");

	a_move_xor_capture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(issue_move && capture_picture))
		else $error("move and capture in one result");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_quick |=> out_valid_q && (state_q == mbfc_pkg::ST_IDLE))
		else $error("tick or quiet frame result missing");

	a_hold_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_scan && hold_passed |=> ticks_q == '0 && issue_move_q)
		else $error("hold not restarted after a move");

	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		load_scan |-> $past(state_q == mbfc_pkg::ST_SCAN, WINDOW_LEN))
		else $error("decision taken before the chain settled");

endmodule

FILE: hw/rtl/mbfc_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one entry of the left, right and bottom edge windows. Entries shift
// one cell along on each motion frame; a running min/max passes through the
// cell to its neighbour every cycle.
// ----------------------------------------------------------------------------
module mbfc_cell #(
	parameter int COORD_BITS = mbfc_pkg::COORD_BITS_DEF,
	parameter logic [COORD_BITS-1:0] LEFT_RESET = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift_en,
	input  logic [COORD_BITS-1:0] left_in,
	input  logic [COORD_BITS-1:0] right_in,
	input  logic [COORD_BITS-1:0] bottom_in,
	input  logic [COORD_BITS-1:0] min_left_in,
	input  logic [COORD_BITS-1:0] max_right_in,
	input  logic [COORD_BITS-1:0] max_bottom_in,
	output logic [COORD_BITS-1:0] left_out,
	output logic [COORD_BITS-1:0] right_out,
	output logic [COORD_BITS-1:0] bottom_out,
	output logic [COORD_BITS-1:0] min_left_out,
	output logic [COORD_BITS-1:0] max_right_out,
	output logic [COORD_BITS-1:0] max_bottom_out
);

	logic [COORD_BITS-1:0] left_q, right_q, bottom_q;
	logic [COORD_BITS-1:0] min_left_q, max_right_q, max_bottom_q;

	// Window entry, shifted in from the previous cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= LEFT_RESET;
			right_q  <= '0;
			bottom_q <= '0;
		end else if (shift_en) begin
			left_q   <= left_in;
			right_q  <= right_in;
			bottom_q <= bottom_in;
		end
	end

	// Running extremes, one cell further each cycle
	always_ff @(posedge clk) begin
		min_left_q   <= (left_q < min_left_in) ? left_q : min_left_in;
		max_right_q  <= (right_q > max_right_in) ? right_q : max_right_in;
		max_bottom_q <= (bottom_q > max_bottom_in) ? bottom_q : max_bottom_in;
	end

	assign left_out       = left_q;
	assign right_out      = right_q;
	assign bottom_out     = bottom_q;
	assign min_left_out   = min_left_q;
	assign max_right_out  = max_right_q;
	assign max_bottom_out = max_bottom_q;

endmodule
